### rtl/noise_source_health_test_top_macros.svh
// assertion macros for the noise source health test block
// used by the rtl files that carry concurrent checks; needs clk and rst in scope
`ifndef NOISE_SOURCE_HEALTH_TEST_TOP_MACROS_SVH
`define NOISE_SOURCE_HEALTH_TEST_TOP_MACROS_SVH
`ifndef SYNTHESIS
// check that is off while rst is high
`define NSHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also covers the reset cycles
`define NSHT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NSHT_ASSERT(label, prop, msg)
`define NSHT_ASSERT_RST(label, prop, msg)
`endif
`endif

### rtl/nsht_pkg.sv
// shared types and constants of the noise source health test block
// no dependencies; imported by every rtl module of the block
package nsht_pkg;

  localparam int SHORT_WINDOW = 64;
  localparam int LONG_WINDOW  = 4096;

  // window position and match count must hold the window size itself
  localparam int SHORT_POS_W = $clog2(SHORT_WINDOW + 1);
  localparam int LONG_POS_W  = $clog2(LONG_WINDOW + 1);

  localparam int SAMPLE_W  = 8;
  localparam int RUN_W     = 8;
  localparam int COUNT_W   = 16;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  // opcodes
  localparam logic OP_TEST  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // register indexes (byte address 4*index)
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_CUTOFF = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_CUTOFF  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG_CUTOFF   = 2'd2;

  localparam logic [RUN_W-1:0]       REPEAT_CUTOFF_RST = 8'd9;
  localparam logic [SHORT_POS_W-1:0] SHORT_CUTOFF_RST  = SHORT_POS_W'(18);
  localparam logic [LONG_POS_W-1:0]  LONG_CUTOFF_RST   = LONG_POS_W'(315);

  typedef struct packed {
    logic [RUN_W-1:0]       repeat_cutoff;
    logic [SHORT_POS_W-1:0] short_cutoff;
    logic [LONG_POS_W-1:0]  long_cutoff;
  } cfg_t;

  typedef struct packed {
    logic long_fail;
    logic short_fail;
    logic repeat_fail;
  } fail_t;

  typedef struct packed {
    logic [2:0]         flags;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] repeat_count;
    logic [COUNT_W-1:0] short_count;
    logic [COUNT_W-1:0] long_count;
  } tally_t;

endpackage

### rtl/noise_source_health_test_top.sv
// top level of the noise source health test block: stream ports, apb port
// depends on nsht_pkg, nsht_cfg, nsht_tests and nsht_tally
//
// Online health checks for a stream of noise bytes. Each input word is either a byte to test
// (tuser = 0) or a command that clears the sticky failure flags (tuser = 1). A byte runs
// through a repetition count test and two adaptive proportion tests (64 and 4096 sample
// windows), and each input word yields exactly one result word with the three per-byte fail
// bits, the sticky flags and four 16-bit wrapping failure counters as they stand after that
// word. One word is taken per clock cycle while the result stream is not stalled; a word goes
// from the input register to the result register, which holds its result valid on the output.
// The update of the test state (run counter and window counters, each one compare and one
// increment) sets that rate. The output register keeps its word while the sink stalls and
// the input register takes the next word meanwhile. No clearing pass follows reset. The user
// writes the cutoffs through the apb port only while the stream is idle (the block does not
// enforce it): 0x0 repetition cutoff, 0x4 short window cutoff, 0x8 long window cutoff.
module noise_source_health_test_top
  import nsht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] sample
  input  logic              s_tuser,   // [0] opcode
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // [0] repeat_fail, [1] short_window_fail, [2] long_window_fail, [5:3] sticky_flags,
  // [21:6] total_failures, [37:22] repeat_failures, [53:38] short_window_failures,
  // [69:54] long_window_failures, [71:70] zero
  output logic [71:0]       m_tdata,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // input register
  logic                in_valid;
  logic                in_opcode;
  logic [SAMPLE_W-1:0] in_sample;

  cfg_t   cfg;
  fail_t  fails;
  tally_t tally_next;
  logic   advance;

  // the held word moves on when the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode <= s_tuser;
      in_sample <= s_tdata;
    end
  end

  nsht_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nsht_tests u_tests (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .opcode (in_opcode),
    .sample (in_sample),
    .cfg    (cfg),
    .fails  (fails)
  );

  nsht_tally u_tally (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .opcode     (in_opcode),
    .fails      (fails),
    .tally_next (tally_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00,
                  tally_next.long_count,
                  tally_next.short_count,
                  tally_next.repeat_count,
                  tally_next.total,
                  tally_next.flags,
                  fails.long_fail,
                  fails.short_fail,
                  fails.repeat_fail};
    end
  end

endmodule

### rtl/nsht_cfg.sv
// apb register file: repetition cutoff and the two window cutoffs
// depends on nsht_pkg
module nsht_cfg
  import nsht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_cutoff <= REPEAT_CUTOFF_RST;
      cfg.short_cutoff  <= SHORT_CUTOFF_RST;
      cfg.long_cutoff   <= LONG_CUTOFF_RST;
    end else if (wr) begin
      case (idx)
        REG_REPEAT_CUTOFF: cfg.repeat_cutoff <= pwdata[RUN_W-1:0];
        REG_SHORT_CUTOFF:  cfg.short_cutoff  <= pwdata[SHORT_POS_W-1:0];
        REG_LONG_CUTOFF:   cfg.long_cutoff   <= pwdata[LONG_POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REPEAT_CUTOFF: prdata = DATA_W'(cfg.repeat_cutoff);
      REG_SHORT_CUTOFF:  prdata = DATA_W'(cfg.short_cutoff);
      REG_LONG_CUTOFF:   prdata = DATA_W'(cfg.long_cutoff);
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/nsht_tests.sv
// repetition count test and the two adaptive proportion windows
// depends on nsht_pkg and the assertion macro header
`include "noise_source_health_test_top_macros.svh"
module nsht_tests
  import nsht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                opcode,
  input  logic [SAMPLE_W-1:0] sample,
  input  cfg_t                cfg,
  output fail_t               fails
);

  logic [SAMPLE_W-1:0]    run_value;
  logic [RUN_W-1:0]       run_length;
  logic [SAMPLE_W-1:0]    short_reference;
  logic [SHORT_POS_W-1:0] short_position;
  logic [SHORT_POS_W-1:0] short_matches;
  logic [SAMPLE_W-1:0]    long_reference;
  logic [LONG_POS_W-1:0]  long_position;
  logic [LONG_POS_W-1:0]  long_matches;

  logic                   test;
  logic                   run_same;
  logic [RUN_W-1:0]       run_length_next;
  logic                   short_wrap;
  logic                   short_hit;
  logic [SHORT_POS_W-1:0] short_matches_next;
  logic                   long_wrap;
  logic                   long_hit;
  logic [LONG_POS_W-1:0]  long_matches_next;

  assign test = (opcode == OP_TEST);

  // run length saturates at its top value
  assign run_same        = (run_value == sample);
  assign run_length_next = (run_length == {RUN_W{1'b1}}) ? run_length : run_length + 1'b1;

  assign short_wrap         = (short_position >= SHORT_POS_W'(SHORT_WINDOW));
  assign short_hit          = (short_reference == sample);
  assign short_matches_next = short_matches + 1'b1;

  assign long_wrap         = (long_position >= LONG_POS_W'(LONG_WINDOW));
  assign long_hit          = (long_reference == sample);
  assign long_matches_next = long_matches + 1'b1;

  assign fails.repeat_fail = test && run_same && (run_length_next >= cfg.repeat_cutoff);
  assign fails.short_fail  = test && !short_wrap && short_hit
                             && (short_matches_next > cfg.short_cutoff);
  assign fails.long_fail   = test && !long_wrap && long_hit
                             && (long_matches_next > cfg.long_cutoff);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value       <= '0;
      run_length      <= '0;
      short_reference <= '0;
      short_position  <= '0;
      short_matches   <= '0;
      long_reference  <= '0;
      long_position   <= '0;
      long_matches    <= '0;
    end else if (en && test) begin
      if (run_same) begin
        run_length <= run_length_next;
      end else begin
        run_value  <= sample;
        run_length <= RUN_W'(1);
      end
      // window full: this byte becomes the new reference
      if (short_wrap) begin
        short_reference <= sample;
        short_position  <= '0;
        short_matches   <= '0;
      end else begin
        short_position <= short_position + 1'b1;
        if (short_hit) begin
          short_matches <= short_matches_next;
        end
      end
      if (long_wrap) begin
        long_reference <= sample;
        long_position  <= '0;
        long_matches   <= '0;
      end else begin
        long_position <= long_position + 1'b1;
        if (long_hit) begin
          long_matches <= long_matches_next;
        end
      end
    end
  end

  `NSHT_ASSERT(a_short_matches_bound, short_matches <= short_position, "short matches beyond position")
  `NSHT_ASSERT(a_long_matches_bound, long_matches <= long_position, "long matches beyond position")
  `NSHT_ASSERT(a_run_started, (en && test) |=> (run_length != '0), "run length zero after a sample")
  `NSHT_ASSERT(a_clear_keeps_run, (en && !test) |=> $stable(run_length), "clear changed run state")
  `NSHT_ASSERT_RST(a_reset_run, rst |=> (run_length == '0), "run length not cleared by reset")

endmodule

### rtl/nsht_tally.sv
// sticky failure flags and the wrapping failure counters
// depends on nsht_pkg
module nsht_tally
  import nsht_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   opcode,
  input  fail_t  fails,
  output tally_t tally_next
);

  tally_t     tally;
  logic [1:0] fail_count;

  assign fail_count = 2'(fails.repeat_fail) + 2'(fails.short_fail) + 2'(fails.long_fail);

  always_comb begin
    tally_next = tally;
    if (opcode == OP_CLEAR) begin
      tally_next.flags = '0;
    end else begin
      tally_next.flags        = tally.flags | fails;
      tally_next.total        = tally.total + COUNT_W'(fail_count);
      tally_next.repeat_count = tally.repeat_count + COUNT_W'(fails.repeat_fail);
      tally_next.short_count  = tally.short_count + COUNT_W'(fails.short_fail);
      tally_next.long_count   = tally.long_count + COUNT_W'(fails.long_fail);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (en) begin
      tally <= tally_next;
    end
  end

endmodule
